### rtl/core/assert_macros.svh
// Assertion macros used by the top level of the round key expansion block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a plain condition at every clock edge outside reset.
`define LRK_ASSERT(lbl, clk_sig, rstn_sig, cond) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (cond)) \
        else $error("assertion failed: lbl");

// Checks that an antecedent implies a consequent in the same cycle.
`define LRK_ASSERT_SAME(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// Checks that an antecedent implies a consequent in the next cycle.
`define LRK_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`else

`define LRK_ASSERT(lbl, clk_sig, rstn_sig, cond)
`define LRK_ASSERT_SAME(lbl, clk_sig, rstn_sig, ante, cons)
`define LRK_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons)

`endif

`endif

### rtl/core/lrk_pkg.sv
// Package with types, constants and helper functions of the round key expansion block.
package lrk_pkg;

    // Key length selector codes as they arrive on the request side.
    localparam logic [1:0] KEY_LEN_128     = 2'd0;
    localparam logic [1:0] KEY_LEN_192     = 2'd1;
    localparam logic [1:0] KEY_LEN_256     = 2'd2;
    // Selector value three is decoded by its high bit and runs the 256-bit schedule.
    localparam logic [1:0] KEY_LEN_256_ALT = 2'd3;

    // Internal key mode; selector value three decodes as the 256-bit mode.
    typedef enum logic [1:0] {
        MODE_128 = 2'd0,
        MODE_192 = 2'd1,
        MODE_256 = 2'd2
    } lrk_mode_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_RUN  = 2'd1,
        ST_EMIT = 2'd2
    } lrk_state_t;

    localparam int WORD_W    = 32;
    localparam int KEY_WORDS = 8;
    localparam int RK_WORDS  = 6;
    localparam int ROUND_W   = 5;
    localparam int SLOT_W    = 3;
    localparam int IDX_W     = 3;
    localparam int DSEL_W    = 3;

    // Delta constants, selected by round number modulo the table span of the mode.
    localparam logic [WORD_W-1:0] DELTA [KEY_WORDS] = '{
        32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec,
        32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957
    };

    // Per-slot rotation applied to each updated working word.
    localparam logic [4:0] SLOT_ROT [RK_WORDS] = '{
        5'd1, 5'd3, 5'd6, 5'd11, 5'd13, 5'd17
    };

    // Control bundle from the sequencer to the datapath.
    typedef struct packed {
        logic                idle;
        logic                load;
        logic                run;
        logic                emit;
        lrk_mode_t           mode;
        logic [IDX_W-1:0]    idx;
        logic [SLOT_W-1:0]   slot;
        logic [4:0]          rot;
        logic [DSEL_W-1:0]   dsel;
        logic [ROUND_W-1:0]  round;
        logic                last;
    } lrk_ctrl_t;

    // Rotate a word left by n bits.
    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] v,
                                                 input logic [4:0] n);
        logic [2*WORD_W-1:0] w;
        w = {v, v} << n;
        return w[2*WORD_W-1:WORD_W];
    endfunction

    // Map the request selector onto the internal mode.
    function automatic lrk_mode_t decode_mode(input logic [1:0] key_length);
        lrk_mode_t m;
        if (key_length[1])
            m = MODE_256;
        else if (key_length == KEY_LEN_192)
            m = MODE_192;
        else
            m = MODE_128;
        return m;
    endfunction

endpackage

### rtl/core/lea_round_key_expansion_top.sv
// Top level of the LEA round key expansion block with its stream ports.
// After a key request is taken, the sequencer updates the working words over four slots
// (128-bit) or six slots (192/256-bit) and then offers the round key; each further round key
// is computed only after the previous one is taken, as the single word update unit handles
// one key word per cycle.
// Reset is asynchronous and active low; it returns the sequencer to idle with no output valid.
`include "assert_macros.svh"

module lea_round_key_expansion_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // key_word0 .. key_word7, 32 bits each, from the lowest bit
    input  logic [1:0]   s_tuser,   // key_length
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // round_index (5), rk0 .. rk5 (32 each), 3 zero bits
    output logic         m_tlast    // last_round
);
    import lrk_pkg::*;

    lrk_ctrl_t          ctrl;
    logic [WORD_W-1:0]  t_reg [KEY_WORDS];
    logic [WORD_W-1:0]  rk_reg [RK_WORDS];
    logic [WORD_W-1:0]  unit_out;
    logic [WORD_W-1:0]  rk_out [RK_WORDS];

    // Round and slot sequencer.
    lrk_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .key_length (s_tuser),
        .m_tready   (m_tready),
        .ctrl       (ctrl)
    );

    // Shared adder and rotator for the working words.
    lrk_word_unit u_word_unit (
        .word   (t_reg[ctrl.idx]),
        .dsel   (ctrl.dsel),
        .rot    (ctrl.rot),
        .slot   (ctrl.slot),
        .result (unit_out)
    );

    // Working key words: loaded from the request, then updated one slot per cycle while a round runs.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int k = 0; k < KEY_WORDS; k++)
                t_reg[k] <= s_tdata[k*WORD_W +: WORD_W];
        end
        else if (ctrl.run)
        begin
            t_reg[ctrl.idx] <= unit_out;
        end
    end

    // Round key words collected in slot order.
    always_ff @(posedge clk)
    begin
        if (ctrl.run)
            rk_reg[ctrl.slot] <= unit_out;
    end

    // The 128-bit mode repeats word one in three slots.
    always_comb
    begin
        for (int k = 0; k < RK_WORDS; k++)
            rk_out[k] = rk_reg[k];
        if (ctrl.mode == MODE_128)
        begin
            rk_out[3] = rk_reg[1];
            rk_out[4] = rk_reg[3];
            rk_out[5] = rk_reg[1];
        end
    end

    // Stream ports.
    assign s_tready = ctrl.idle;
    assign m_tvalid = ctrl.emit;
    assign m_tlast  = ctrl.last;
    assign m_tdata  = {3'b000, rk_out[5], rk_out[4], rk_out[3], rk_out[2], rk_out[1],
                       rk_out[0], ctrl.round};

    // The block never takes a key while a round key is offered.
    `LRK_ASSERT(a_no_overlap, clk, rst_n, !(s_tready && m_tvalid))
    // A taken key starts computation, with neither side active in the next cycle.
    `LRK_ASSERT_NEXT(a_load_starts_run, clk, rst_n, s_tvalid && s_tready, !s_tready && !m_tvalid)
    // The last flag only marks the final round of one of the three schedules.
    `LRK_ASSERT_SAME(a_last_round_index, clk, rst_n, m_tvalid && m_tlast,
        m_tdata[4:0] == 5'd23 || m_tdata[4:0] == 5'd27 || m_tdata[4:0] == 5'd31)
    // After a round key other than the last is taken, the next one is still being computed.
    `LRK_ASSERT_NEXT(a_gap_after_round, clk, rst_n, m_tvalid && m_tready && !m_tlast,
        !m_tvalid && !s_tready)

endmodule

### rtl/core/lrk_word_unit.sv
// Shared word update unit: adds a rotated delta to a working word and rotates the sum.
module lrk_word_unit (
    input  logic [lrk_pkg::WORD_W-1:0] word,
    input  logic [lrk_pkg::DSEL_W-1:0] dsel,
    input  logic [4:0]                 rot,
    input  logic [lrk_pkg::SLOT_W-1:0] slot,
    output logic [lrk_pkg::WORD_W-1:0] result
);
    import lrk_pkg::*;

    logic [WORD_W-1:0] delta_rot;
    logic [WORD_W-1:0] sum;
    logic [4:0]        srot;

    // Delta rotated by round plus slot, added to the working word.
    assign delta_rot = rotl32(DELTA[dsel], rot);
    assign sum       = word + delta_rot;

    // Slot codes above five never occur; they take no rotation.
    always_comb
    begin
        if (slot < SLOT_W'(RK_WORDS))
            srot = SLOT_ROT[slot];
        else
            srot = 5'd0;
    end

    assign result = rotl32(sum, srot);

endmodule

### rtl/core/lrk_ctrl.sv
// Sequencer that walks rounds and word slots and drives the shared update unit.
module lrk_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic [1:0]        key_length,
    input  logic              m_tready,
    output lrk_pkg::lrk_ctrl_t ctrl
);
    import lrk_pkg::*;

    lrk_state_t          state_reg, state_next;
    lrk_mode_t           mode_reg, mode_next;
    logic [ROUND_W-1:0]  round_reg, round_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [IDX_W-1:0]    base_reg, base_next;
    logic [DSEL_W-1:0]   dsel_reg, dsel_next;

    logic [SLOT_W-1:0]   last_slot;
    logic [ROUND_W-1:0]  last_round;
    logic [DSEL_W-1:0]   last_dsel;
    logic                is_last;

    // Limits that depend on the key mode.
    always_comb
    begin
        unique case (mode_reg)
            MODE_128:
            begin
                last_slot  = SLOT_W'(3);
                last_round = ROUND_W'(23);
                last_dsel  = DSEL_W'(3);
            end
            MODE_192:
            begin
                last_slot  = SLOT_W'(5);
                last_round = ROUND_W'(27);
                last_dsel  = DSEL_W'(5);
            end
            MODE_256:
            begin
                last_slot  = SLOT_W'(5);
                last_round = ROUND_W'(31);
                last_dsel  = DSEL_W'(7);
            end
            default:
            begin
                last_slot  = SLOT_W'(5);
                last_round = ROUND_W'(31);
                last_dsel  = DSEL_W'(7);
            end
        endcase
    end

    assign is_last = (round_reg == last_round);

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_128;
            round_reg <= '0;
            slot_reg  <= '0;
            base_reg  <= '0;
            dsel_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            round_reg <= round_next;
            slot_reg  <= slot_next;
            base_reg  <= base_next;
            dsel_reg  <= dsel_next;
        end
    end

    // Next state: one slot update per cycle in the run state, then the emit state holds until the round key is taken.
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        round_next = round_reg;
        slot_next  = slot_reg;
        base_next  = base_reg;
        dsel_next  = dsel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_RUN;
                    mode_next  = decode_mode(key_length);
                    round_next = '0;
                    slot_next  = '0;
                    base_next  = '0;
                    dsel_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (slot_reg == last_slot)
                begin
                    state_next = ST_EMIT;
                    slot_next  = '0;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                        round_next = round_reg + ROUND_W'(1);
                        // The 256-bit mode steps its word window by six each round.
                        base_next  = base_reg + IDX_W'(6);
                        dsel_next  = (dsel_reg == last_dsel) ? '0 : dsel_reg + DSEL_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control bundle for the datapath.
    always_comb
    begin
        ctrl.idle  = (state_reg == ST_IDLE);
        ctrl.load  = (state_reg == ST_IDLE) && s_tvalid;
        ctrl.run   = (state_reg == ST_RUN);
        ctrl.emit  = (state_reg == ST_EMIT);
        ctrl.mode  = mode_reg;
        ctrl.idx   = (mode_reg == MODE_256) ? base_reg + IDX_W'(slot_reg) : IDX_W'(slot_reg);
        ctrl.slot  = slot_reg;
        ctrl.rot   = round_reg + 5'(slot_reg);
        ctrl.dsel  = dsel_reg;
        ctrl.round = round_reg;
        ctrl.last  = is_last;
    end

endmodule
